FILE: rtl/lik_pkg.sv
// Package for the leg inverse kinematics block: fixed-point formats, angle constants,
// pipeline sideband type, square root and CORDIC step helpers.
// No dependencies.
package lik_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int Q_BITS          = 28;
    localparam int OUT_SHIFT       = Q_BITS - ANGLE_FRAC_BITS;
    localparam int RYZ_FRAC        = 15;

    localparam int CORDIC_STEPS = 28;
    localparam int NORM_STAGES  = 3;
    localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_STEPS;
    localparam int SQRT_STEPS   = 31;

    localparam int SQ_W  = 62;
    localparam int CW    = 44;
    localparam int OPW   = 34;
    localparam int ANG_W = 32;
    localparam int ACC_W = 40;

    localparam logic signed [ANG_W-1:0] PI   = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] PI_2 = 32'sd421657428;

    localparam logic [1:0] REG_THIGH    = 2'd0;
    localparam logic [1:0] REG_SHANK    = 2'd1;
    localparam logic [1:0] REG_ROT_EN   = 2'd2;
    localparam logic [1:0] REG_BODY_ROT = 2'd3;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [11] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
        32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
        32'sd262144
    };

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               clamped;
        logic signed [31:0] hip_num;
        logic signed [31:0] knee_num;
        logic               hip_zero;
        logic               hip_ge;
        logic               knee_zero;
        logic               knee_ge;
    } t_side;

    // One step of the bit-by-bit floor square root, step k tests bit 2^(60-2k).
    function automatic t_sq lik_sqrt_step(t_sq s, int k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] sum;
        t_sq             r;
        bitv = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        sum  = s.root + bitv;
        if (s.rem >= sum) begin
            r.rem  = s.rem - sum;
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] lik_atan_step(int i);
        if (i < 11) begin
            return ATAN_TAB[4'(i)];
        end
        return 32'sd1 <<< (Q_BITS - i);
    endfunction

    function automatic logic signed [ACC_W-1:0] lik_widen(logic signed [15:0] v);
        return ACC_W'(v) <<< OUT_SHIFT;
    endfunction

    // Round to nearest with ties upward, then saturate to 16 bits.
    function automatic logic signed [15:0] lik_to_out(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = (v + (ACC_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > 32767) begin
            return 16'sh7fff;
        end else if (r < -32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage

FILE: rtl/lik_atan2.sv
// Pipelined atan2 in Q.28 radians: quadrant fold, three normalizing stages and
// 28 vectoring CORDIC iterations, one per stage. Depends on lik_pkg.
module lik_atan2
    import lik_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [OPW-1:0]   i_y,
    input  logic signed [OPW-1:0]   i_x,
    output logic signed [ANG_W-1:0] o_angle
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] m;
    } t_nrm;

    // Shift left by sh when the larger magnitude stays below 2^41.
    function automatic t_nrm norm_step(t_nrm v, int sh);
        if (v.m < (CW'(1) <<< (41 - sh))) begin
            v.x = v.x <<< sh;
            v.y = v.y <<< sh;
            v.m = v.m <<< sh;
        end
        return v;
    endfunction

    logic signed [CW-1:0]    xe;
    logic signed [CW-1:0]    ye;
    logic signed [CW-1:0]    ay;
    t_nrm                    n_prep;
    logic signed [ANG_W-1:0] n_pz;
    logic                    n_pf;

    t_nrm                    r_nv [0:NORM_STAGES-1];
    logic signed [ANG_W-1:0] r_nz [0:NORM_STAGES-1];
    logic                    r_nf [0:NORM_STAGES-1];
    t_nrm                    n_last;

    logic signed [CW-1:0]    r_cx [0:CORDIC_STEPS];
    logic signed [CW-1:0]    r_cy [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_cz [0:CORDIC_STEPS];
    logic                    r_cf [0:CORDIC_STEPS];

    always_comb begin
        xe   = CW'(i_x);
        ye   = CW'(i_y);
        n_pz = '0;
        if (xe < 0) begin
            n_pz = (ye >= 0) ? PI : -PI;
            xe   = -xe;
            ye   = -ye;
        end
        ay       = (ye < 0) ? -ye : ye;
        n_prep.x = xe;
        n_prep.y = ye;
        n_prep.m = (xe > ay) ? xe : ay;
        n_pf     = (i_x == '0) && (i_y == '0);
    end

    assign n_last = norm_step(norm_step(r_nv[NORM_STAGES-1], 2), 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nv[0] <= n_prep;
            r_nz[0] <= n_pz;
            r_nf[0] <= n_pf;
            for (int g = 1; g < NORM_STAGES; g++) begin
                r_nv[g] <= norm_step(norm_step(r_nv[g-1], 1 << (7 - 2*g)), 1 << (6 - 2*g));
                r_nz[g] <= r_nz[g-1];
                r_nf[g] <= r_nf[g-1];
            end
            r_cx[0] <= n_last.x;
            r_cy[0] <= n_last.y;
            r_cz[0] <= r_nz[NORM_STAGES-1];
            r_cf[0] <= r_nf[NORM_STAGES-1];
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + lik_atan_step(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - lik_atan_step(i);
                end
                r_cf[i+1] <= r_cf[i];
            end
        end
    end

    // Both operands zero give an angle of zero.
    assign o_angle = r_cf[CORDIC_STEPS] ? '0 : r_cz[CORDIC_STEPS];

endmodule

FILE: rtl/leg_inverse_kinematics.sv
// Top level of the leg inverse kinematics block: squares, reach clamp, three
// pipelined square roots, four atan2 pipelines and the joint angle sums.
// Depends on lik_pkg and lik_atan2.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-----------------------------------
//  foot in  | input     | i_in_valid / o_in_stall   | i_foot_x/y/z, i_foot_yaw
//  joints   | output    | o_out_valid / i_out_stall | six o_*_angle, o_reach_clamped
//  config   | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One transaction is accepted per clock while the output is not stalled; the result path
// runs through the 31-step square root and the 32-stage atan2 pipelines.
// All stages advance together; a stalled output register holds the whole pipeline
// and raises o_in_stall, so nothing is dropped or repeated.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults.
module leg_inverse_kinematics
    import lik_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_foot_x,
    input  logic signed [15:0] i_foot_y,
    input  logic signed [15:0] i_foot_z,
    input  logic signed [15:0] i_foot_yaw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_hip_roll_angle,
    output logic signed [15:0] o_hip_pitch_angle,
    output logic signed [15:0] o_knee_angle,
    output logic signed [15:0] o_ankle_pitch_angle,
    output logic signed [15:0] o_ankle_roll_angle,
    output logic               o_reach_clamped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    localparam int STG_SQ0   = 6;
    localparam int STG_OPND  = STG_SQ0 + SQRT_STEPS + 1;
    localparam int STG_ANG   = STG_OPND + ATAN_LAT;
    localparam int STG_JOINT = STG_ANG + 1;
    localparam int LAST      = STG_JOINT + 1;

    localparam int SQ_RYZ  = 0;
    localparam int SQ_HIP  = 1;
    localparam int SQ_KNEE = 2;

    localparam int AT_ROLL  = 0;
    localparam int AT_HIP   = 1;
    localparam int AT_PITCH = 2;
    localparam int AT_KNEE  = 3;

    logic en;

    // Configuration and values derived from it.
    logic [13:0]        r_thigh;
    logic [13:0]        r_shank;
    logic               r_rot_en;
    logic signed [15:0] r_body_rot;
    logic [27:0]        r_t2;
    logic [27:0]        r_s2;
    logic [29:0]        r_reach2;
    logic [57:0]        r_kden2;
    logic [14:0]        n_reach;
    logic [55:0]        n_kprod;

    logic        r_vld [1:LAST];
    t_side       r_sd  [1:LAST];
    t_side       n_sd  [1:LAST];

    // Early arithmetic stages.
    logic signed [31:0] n2_x2, n2_y2, n2_z2;
    logic [30:0]        r2_x2, r2_y2, r2_z2;
    logic [31:0]        r3_yz2, r3_r2f;
    logic               n4_clamped;
    logic [29:0]        n4_r2;
    logic signed [32:0] n4_hnum, n4_knum;
    logic [29:0]        r4_r2;
    logic [31:0]        r4_yz2;
    logic signed [31:0] n5_habs, n5_kabs;
    logic [61:0]        n5_hn2, n5_kn2;
    logic [57:0]        n5_hden;
    logic [61:0]        r5_hn2, r5_kn2;
    logic [59:0]        r5_hden2;
    logic [31:0]        r5_yz2;
    logic [SQ_W-1:0]    n6_hden, n6_kden;
    logic               n6_hge, n6_kge;

    t_sq  n_sq0 [0:2];
    t_sq  r_sq  [0:SQRT_STEPS][0:2];

    t_side                   sd_op;
    logic signed [OPW-1:0]   ryz_op;
    logic signed [OPW-1:0]   n38_oy [0:3];
    logic signed [OPW-1:0]   n38_ox [0:3];
    logic signed [OPW-1:0]   r38_oy [0:3];
    logic signed [OPW-1:0]   r38_ox [0:3];
    logic signed [ANG_W-1:0] w_ang  [0:3];

    t_side                   sd_ang;
    logic signed [ANG_W-1:0] n71_ahip, n71_kacos, n71_roll;
    logic signed [ACC_W-1:0] n71_pitch;
    logic signed [ACC_W-1:0] r71_roll, r71_pitch, r71_knee;
    logic signed [ACC_W-1:0] n72_rot;
    logic signed [ACC_W-1:0] r72_yaw, r72_roll, r72_pitch, r72_knee, r72_apitch, r72_aroll;

    logic               r_out_valid;
    logic signed [15:0] r_out_yaw, r_out_roll, r_out_pitch, r_out_knee;
    logic signed [15:0] r_out_apitch, r_out_aroll;
    logic               r_out_clamped;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thigh    <= 14'd3584;
            r_shank    <= 14'd3584;
            r_rot_en   <= 1'b0;
            r_body_rot <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THIGH:    r_thigh    <= i_cfg_data[13:0];
                REG_SHANK:    r_shank    <= i_cfg_data[13:0];
                REG_ROT_EN:   r_rot_en   <= i_cfg_data[0];
                REG_BODY_ROT: r_body_rot <= i_cfg_data;
            endcase
        end
    end

    assign n_reach = {1'b0, r_thigh} + {1'b0, r_shank};
    assign n_kprod = r_t2 * r_s2;

    // Link terms are registered from the configuration registers, well before an item needs them.
    always_ff @(posedge i_clk) begin
        r_t2     <= r_thigh * r_thigh;
        r_s2     <= r_shank * r_shank;
        r_reach2 <= n_reach * n_reach;
        r_kden2  <= {n_kprod, 2'b00};
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_in_valid;
            for (int k = 2; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[LAST];
        end
    end

    // Arithmetic of the first stages.
    always_comb begin
        n2_x2 = r_sd[1].x * r_sd[1].x;
        n2_y2 = r_sd[1].y * r_sd[1].y;
        n2_z2 = r_sd[1].z * r_sd[1].z;

        n4_clamped = r3_r2f > {2'b00, r_reach2};
        n4_r2      = n4_clamped ? r_reach2 : r3_r2f[29:0];
        n4_hnum    = $signed({5'b0, r_t2}) + $signed({3'b0, n4_r2}) - $signed({5'b0, r_s2});
        n4_knum    = $signed({5'b0, r_t2}) + $signed({5'b0, r_s2}) - $signed({3'b0, n4_r2});

        n5_habs = (r_sd[4].hip_num < 0) ? -r_sd[4].hip_num : r_sd[4].hip_num;
        n5_kabs = (r_sd[4].knee_num < 0) ? -r_sd[4].knee_num : r_sd[4].knee_num;
        n5_hn2  = n5_habs[30:0] * n5_habs[30:0];
        n5_kn2  = n5_kabs[30:0] * n5_kabs[30:0];
        n5_hden = r_t2 * r4_r2;

        n6_hden = {2'b00, r5_hden2};
        n6_kden = {4'b0000, r_kden2};
        n6_hge  = r5_hn2 >= n6_hden;
        n6_kge  = r5_kn2 >= n6_kden;

        n_sq0[SQ_RYZ].rem   = {r5_yz2[SQ_W-2*RYZ_FRAC-1:0], (2*RYZ_FRAC)'(0)};
        n_sq0[SQ_RYZ].root  = '0;
        n_sq0[SQ_HIP].rem   = n6_hge ? '0 : n6_hden - r5_hn2;
        n_sq0[SQ_HIP].root  = '0;
        n_sq0[SQ_KNEE].rem  = n6_kge ? '0 : n6_kden - r5_kn2;
        n_sq0[SQ_KNEE].root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x2    <= n2_x2[30:0];
            r2_y2    <= n2_y2[30:0];
            r2_z2    <= n2_z2[30:0];
            r3_yz2   <= {1'b0, r2_y2} + {1'b0, r2_z2};
            r3_r2f   <= {1'b0, r2_x2} + {1'b0, r2_y2} + {1'b0, r2_z2};
            r4_r2    <= n4_r2;
            r4_yz2   <= r3_yz2;
            r5_hn2   <= n5_hn2;
            r5_kn2   <= n5_kn2;
            r5_hden2 <= {n5_hden, 2'b00};
            r5_yz2   <= r4_yz2;
        end
    end

    // Sideband travels with each item; some stages fill in their fields.
    always_comb begin
        n_sd[1]     = '0;
        n_sd[1].yaw = i_foot_yaw;
        n_sd[1].x   = i_foot_x;
        n_sd[1].y   = i_foot_y;
        n_sd[1].z   = i_foot_z;
        for (int k = 2; k <= LAST; k++) begin
            n_sd[k] = r_sd[k-1];
        end
        n_sd[4].clamped   = n4_clamped;
        n_sd[4].hip_num   = n4_hnum[31:0];
        n_sd[4].knee_num  = n4_knum[31:0];
        n_sd[6].hip_zero  = (r5_hden2 == '0);
        n_sd[6].hip_ge    = n6_hge;
        n_sd[6].knee_zero = (r_kden2 == '0);
        n_sd[6].knee_ge   = n6_kge;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= LAST; k++) begin
                r_sd[k] <= n_sd[k];
            end
        end
    end

    // Square roots of y^2+z^2 (scaled) and of the two acos sine terms.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_sq[0][j] <= n_sq0[j];
                for (int k = 1; k <= SQRT_STEPS; k++) begin
                    r_sq[k][j] <= lik_sqrt_step(r_sq[k-1][j], k - 1);
                end
            end
        end
    end

    // atan2 operands; each acos(n/d) is taken as atan2(sqrt(d^2 - n^2), n).
    always_comb begin
        sd_op  = r_sd[STG_OPND-1];
        ryz_op = OPW'({1'b0, r_sq[SQRT_STEPS][SQ_RYZ].root[30:0]});

        n38_oy[AT_ROLL] = OPW'(sd_op.z);
        n38_ox[AT_ROLL] = OPW'(sd_op.y);
        n38_oy[AT_HIP]  = OPW'({1'b0, r_sq[SQRT_STEPS][SQ_HIP].root[30:0]});
        n38_ox[AT_HIP]  = OPW'(sd_op.hip_num);
        n38_oy[AT_KNEE] = OPW'({1'b0, r_sq[SQRT_STEPS][SQ_KNEE].root[30:0]});
        n38_ox[AT_KNEE] = OPW'(sd_op.knee_num);
        if (sd_op.x > 0) begin
            n38_oy[AT_PITCH] = OPW'(sd_op.x) <<< RYZ_FRAC;
            n38_ox[AT_PITCH] = ryz_op;
        end else begin
            n38_oy[AT_PITCH] = ryz_op;
            n38_ox[AT_PITCH] = (-OPW'(sd_op.x)) <<< RYZ_FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < 4; g++) begin
                r38_oy[g] <= n38_oy[g];
                r38_ox[g] <= n38_ox[g];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_atan
        lik_atan2 u_atan (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_y     (r38_oy[g]),
            .i_x     (r38_ox[g]),
            .o_angle (w_ang[g])
        );
    end

    // Joint angles. A zero acos divisor gives angle zero; a cosine of magnitude one
    // or more gives zero or pi by its sign.
    always_comb begin
        sd_ang = r_sd[STG_ANG];

        priority if (sd_ang.hip_zero) begin
            n71_ahip = '0;
        end else if (sd_ang.hip_ge) begin
            n71_ahip = (sd_ang.hip_num < 0) ? PI : '0;
        end else begin
            n71_ahip = w_ang[AT_HIP];
        end

        priority if (sd_ang.knee_zero) begin
            n71_kacos = '0;
        end else if (sd_ang.knee_ge) begin
            n71_kacos = (sd_ang.knee_num < 0) ? PI : '0;
        end else begin
            n71_kacos = w_ang[AT_KNEE];
        end

        priority if (sd_ang.x == 0) begin
            n71_pitch = ACC_W'(PI_2) - ACC_W'(n71_ahip);
        end else if (sd_ang.x > 0) begin
            n71_pitch = ACC_W'(PI_2) - ACC_W'(n71_ahip) - ACC_W'(w_ang[AT_PITCH]);
        end else begin
            n71_pitch = ACC_W'(PI) - ACC_W'(n71_ahip) - ACC_W'(w_ang[AT_PITCH]);
        end

        n71_roll = (sd_ang.y == 0) ? PI_2 : w_ang[AT_ROLL];
        n72_rot  = r_rot_en ? lik_widen(r_body_rot) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r71_roll   <= ACC_W'(n71_roll);
            r71_pitch  <= n71_pitch;
            r71_knee   <= ACC_W'(PI) - ACC_W'(n71_kacos);

            r72_yaw    <= lik_widen(r_sd[STG_JOINT].yaw) + ACC_W'(PI_2);
            r72_roll   <= r71_roll;
            r72_pitch  <= r71_pitch;
            r72_knee   <= r71_knee;
            r72_apitch <= ACC_W'(PI) - r71_pitch - r71_knee;
            r72_aroll  <= ACC_W'(PI) - r71_roll - n72_rot;

            r_out_yaw     <= lik_to_out(r72_yaw);
            r_out_roll    <= lik_to_out(r72_roll);
            r_out_pitch   <= lik_to_out(r72_pitch);
            r_out_knee    <= lik_to_out(r72_knee);
            r_out_apitch  <= lik_to_out(r72_apitch);
            r_out_aroll   <= lik_to_out(r72_aroll);
            r_out_clamped <= r_sd[LAST].clamped;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_yaw_angle         = r_out_yaw;
    assign o_hip_roll_angle    = r_out_roll;
    assign o_hip_pitch_angle   = r_out_pitch;
    assign o_knee_angle        = r_out_knee;
    assign o_ankle_pitch_angle = r_out_apitch;
    assign o_ankle_roll_angle  = r_out_aroll;
    assign o_reach_clamped     = r_out_clamped;

endmodule
